// ===== hdl/sfs_pkg.sv =====
// Shared types and constants of the state-space filter step.
package sfs_pkg;

	localparam int SAMPLE_W    = 16;
	localparam int COEF_W      = 24;
	localparam int STATE_W     = 32;
	localparam int STATE_EXTRA = 8;
	localparam int PROD_W      = COEF_W + STATE_W;
	localparam int CFG_W       = 3;

	localparam logic [1:0] KIND_SAMPLE = 2'd0;
	localparam logic [1:0] KIND_COEF   = 2'd1;
	localparam logic [1:0] KIND_CLEAR  = 2'd2;

	typedef struct packed {
		logic [1:0]                 kind;
		logic [4:0]                 coef_index;
		logic signed [COEF_W-1:0]   coef_value;
		logic signed [SAMPLE_W-1:0] sample_in;
	} in_word_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample_out;
		logic                       saturated;
	} out_word_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ISSUE,
		ST_DRAIN,
		ST_EMIT
	} seq_state_t;

	typedef struct packed {
		logic vld;
		logic first;
		logic last;
		logic out_row;
		logic final_term;
	} mac_ctrl_t;

endpackage

// ===== hdl/sfs_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
module sfs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== hdl/state_space_filter_step_top.sv =====
// Top level of the fixed-point state-space filter step.
//
//  channel | direction | handshake         | word
//  --------+-----------+-------------------+-----------------------------------------
//  req     | in        | req_valid/stall   | in_word_t: kind, coef_index, value, sample
//  rsp     | out       | rsp_valid/stall   | out_word_t: sample_out, saturated
//  cfg     | in        | cfg_we            | cfg_data: states_in_use
//
// A sample word runs (n+1)*(n+1) coefficient products, n being states in use.
// Its run time is set by the single multiply-accumulate, which takes one coefficient
// product a cycle, and by the one read port of each memory.
// Coefficient writes, state clears and unused kinds leave the block idle and ready for the next word.
// Reset clears all coefficients and states at once through per-entry valid bits.
// A finished result waits in the output register; a new word is taken meanwhile,
// and the block holds its next result until the waiting one has gone.
module state_space_filter_step_top
	import sfs_pkg::*;
#(
	parameter int STATES         = 4,
	parameter int COEF_FRAC_BITS = 18
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_stall,
	input  in_word_t         req_word,
	output logic             rsp_valid,
	input  logic             rsp_stall,
	output out_word_t        rsp_word,
	input  logic             cfg_we,
	input  logic [CFG_W-1:0] cfg_data
);

	// Coefficient layout: Phi row-major, then Gamma, then H, then J.
	localparam int COEF_COUNT = STATES * STATES + 2 * STATES + 1;
	localparam int GAMMA_BASE = STATES * STATES;
	localparam int H_BASE     = GAMMA_BASE + STATES;
	localparam int J_ADDR     = H_BASE + STATES;
	localparam int COEF_AW    = $clog2(COEF_COUNT);
	localparam int CNT_W      = $clog2(STATES + 1);
	localparam int IDX_W      = (STATES > 1) ? $clog2(STATES) : 1;
	localparam int SADDR_W    = $clog2(2 * STATES);
	localparam int ACC_W      = PROD_W + $clog2(STATES + 2);
	localparam int Y_SHIFT    = COEF_FRAC_BITS + STATE_EXTRA;

	localparam logic [CNT_W-1:0] CFG_RST = CNT_W'((STATES < 4) ? STATES : 4);

	// Rounding offsets are folded into the first term of each row.
	localparam logic signed [ACC_W-1:0] RND_Y = ACC_W'(64'd1 << (Y_SHIFT - 1));
	localparam logic signed [ACC_W-1:0] RND_X = ACC_W'(64'd1 << (COEF_FRAC_BITS - 1));
	localparam logic signed [ACC_W-1:0] Y_MAX = ACC_W'(64'd32767);
	localparam logic signed [ACC_W-1:0] Y_MIN = -ACC_W'(64'd32768);
	localparam logic signed [ACC_W-1:0] X_MAX = ACC_W'(64'h7FFF_FFFF);
	localparam logic signed [ACC_W-1:0] X_MIN = -ACC_W'(64'h8000_0000);

	seq_state_t state_q, state_d;

	logic                 req_fire;
	logic                 rsp_fire;
	logic                 issue;
	logic                 emit;

	logic [CNT_W-1:0]     cfg_q;
	logic [CNT_W-1:0]     row_q;
	logic [CNT_W-1:0]     col_q;
	logic                 sat_q;
	logic [COEF_COUNT-1:0] coef_vld_q;
	logic [STATES-1:0]    state_vld_q;
	logic [STATES-1:0]    bank_q;

	logic signed [SAMPLE_W-1:0] u_q;
	logic signed [SAMPLE_W-1:0] y_q;
	logic                       rsp_valid_q;
	out_word_t                  rsp_word_q;

	// Read side of the sequencer.
	logic [COEF_AW-1:0]   coef_raddr;
	logic [IDX_W-1:0]     sidx;
	logic [SADDR_W-1:0]   state_raddr;
	logic [COEF_W-1:0]    coef_rdata;
	logic [STATE_W-1:0]   state_rdata;
	logic                 coef_we;

	// MAC pipeline.
	mac_ctrl_t            ctrl_s1, ctrl_s2, ctrl_s3;
	logic [IDX_W-1:0]     idx_s1, idx_s2, idx_s3;
	logic                 coef_vld_s1;
	logic                 state_vld_s1;
	logic signed [COEF_W-1:0]  op_a;
	logic signed [STATE_W-1:0] op_b;
	logic signed [PROD_W-1:0]  product_s2;
	logic signed [ACC_W-1:0]   acc_q;

	// Row finish.
	logic signed [ACC_W-1:0]    y_full;
	logic signed [ACC_W-1:0]    x_full;
	logic                       y_clip;
	logic                       x_clip;
	logic signed [SAMPLE_W-1:0] y_sat;
	logic signed [STATE_W-1:0]  x_sat;
	logic                       y_done;
	logic                       x_done;
	logic [SADDR_W-1:0]         state_waddr;

	assign req_fire = req_valid & ~req_stall;
	assign rsp_fire = rsp_valid_q & ~rsp_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp_word  = rsp_word_q;

	// ---------------------------------------------------------------- sequencer

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		req_stall = 1'b1;
		issue     = 1'b0;
		emit      = 1'b0;
		case (state_q)
			ST_IDLE: begin
				req_stall = 1'b0;
				if (req_valid && req_word.kind == KIND_SAMPLE) begin
					state_d = ST_ISSUE;
				end
			end
			ST_ISSUE: begin
				issue = 1'b1;
				if (row_q == cfg_q && col_q == cfg_q) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				// wait for the last term of the last row to leave the pipeline
				if (ctrl_s3.vld && ctrl_s3.final_term) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				// hold the result until the output register is free
				if (!rsp_valid_q || !rsp_stall) begin
					emit    = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Row 0 is the output row (J, then H); row r is state r-1 (Gamma, then Phi).
	// Column 0 is the input term, column c is state c-1.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
			cfg_q <= CFG_RST;
		end else begin
			if (cfg_we) begin
				if (32'(cfg_data) > STATES) begin
					cfg_q <= CNT_W'(STATES);
				end else begin
					cfg_q <= CNT_W'(cfg_data);
				end
			end
			if (req_fire) begin
				row_q <= '0;
				col_q <= '0;
			end else if (issue) begin
				if (col_q == cfg_q) begin
					col_q <= '0;
					row_q <= row_q + 1'b1;
				end else begin
					col_q <= col_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire && req_word.kind == KIND_SAMPLE) begin
			u_q <= req_word.sample_in;
		end
	end

	always_comb begin
		int a;
		a = 0;
		if (row_q == '0) begin
			a = (col_q == '0) ? J_ADDR : H_BASE + int'(col_q) - 1;
		end else if (col_q == '0) begin
			a = GAMMA_BASE + int'(row_q) - 1;
		end else begin
			a = (int'(row_q) - 1) * STATES + int'(col_q) - 1;
		end
		coef_raddr = COEF_AW'(a);
	end

	assign sidx = (col_q == '0) ? '0 : IDX_W'(col_q - 1'b1);

	// Each state entry lives in one of two banks; reads take the current bank and
	// the new value goes to the other, so no read of a sample meets its own writes.
	assign state_raddr = bank_q[sidx] ? SADDR_W'(STATES) + SADDR_W'(sidx)
	                                  : SADDR_W'(sidx);

	// ---------------------------------------------------------------- memories

	assign coef_we = req_fire && req_word.kind == KIND_COEF
	              && 32'(req_word.coef_index) < COEF_COUNT;

	sfs_ram #(
		.WIDTH (COEF_W),
		.DEPTH (COEF_COUNT)
	) u_coef_ram (
		.clk   (clk),
		.we    (coef_we),
		.waddr (COEF_AW'(req_word.coef_index)),
		.wdata (req_word.coef_value),
		.raddr (coef_raddr),
		.rdata (coef_rdata)
	);

	sfs_ram #(
		.WIDTH (STATE_W),
		.DEPTH (2 * STATES)
	) u_state_ram (
		.clk   (clk),
		.we    (x_done),
		.waddr (state_waddr),
		.wdata (x_sat),
		.raddr (state_raddr),
		.rdata (state_rdata)
	);

	// Valid bits stand in for the zero reset of both memories.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_vld_q  <= '0;
			state_vld_q <= '0;
			bank_q      <= '0;
		end else begin
			if (coef_we) begin
				coef_vld_q[COEF_AW'(req_word.coef_index)] <= 1'b1;
			end
			if (req_fire && req_word.kind == KIND_CLEAR) begin
				state_vld_q <= '0;
			end else if (ctrl_s3.vld && ctrl_s3.final_term) begin
				// commit the new state vector: swap banks of the states in use
				for (int i = 0; i < STATES; i++) begin
					if (i < int'(cfg_q)) begin
						bank_q[i]      <= ~bank_q[i];
						state_vld_q[i] <= 1'b1;
					end
				end
			end
		end
	end

	// ---------------------------------------------------------------- MAC pipeline

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s1 <= '0;
			ctrl_s2 <= '0;
			ctrl_s3 <= '0;
		end else begin
			ctrl_s1.vld        <= issue;
			ctrl_s1.first      <= (col_q == '0);
			ctrl_s1.last       <= (col_q == cfg_q);
			ctrl_s1.out_row    <= (row_q == '0);
			ctrl_s1.final_term <= (row_q == cfg_q) && (col_q == cfg_q);
			ctrl_s2            <= ctrl_s1;
			ctrl_s3            <= ctrl_s2;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1       <= (row_q == '0) ? '0 : IDX_W'(row_q - 1'b1);
		idx_s2       <= idx_s1;
		idx_s3       <= idx_s2;
		coef_vld_s1  <= coef_vld_q[coef_raddr];
		state_vld_s1 <= state_vld_q[sidx];
	end

	// Entries never written read as zero; the input term is u scaled to state format.
	assign op_a = coef_vld_s1 ? signed'(coef_rdata) : '0;
	assign op_b = ctrl_s1.first ? STATE_W'(signed'({u_q, {STATE_EXTRA{1'b0}}}))
	            : (state_vld_s1 ? signed'(state_rdata) : '0);

	always_ff @(posedge clk) begin
		if (ctrl_s1.vld) begin
			product_s2 <= op_a * op_b;
		end
		if (ctrl_s2.vld) begin
			if (ctrl_s2.first) begin
				acc_q <= (ctrl_s2.out_row ? RND_Y : RND_X) + ACC_W'(product_s2);
			end else begin
				acc_q <= acc_q + ACC_W'(product_s2);
			end
		end
	end

	// ---------------------------------------------------------------- row finish

	assign y_full = acc_q >>> Y_SHIFT;
	assign x_full = acc_q >>> COEF_FRAC_BITS;
	assign y_clip = (y_full > Y_MAX) || (y_full < Y_MIN);
	assign x_clip = (x_full > X_MAX) || (x_full < X_MIN);
	assign y_sat  = (y_full > Y_MAX) ? 16'sh7FFF
	              : (y_full < Y_MIN) ? 16'sh8000 : y_full[SAMPLE_W-1:0];
	assign x_sat  = (x_full > X_MAX) ? 32'sh7FFF_FFFF
	              : (x_full < X_MIN) ? 32'sh8000_0000 : x_full[STATE_W-1:0];

	assign y_done = ctrl_s3.vld && ctrl_s3.last && ctrl_s3.out_row;
	assign x_done = ctrl_s3.vld && ctrl_s3.last && !ctrl_s3.out_row;

	assign state_waddr = bank_q[idx_s3] ? SADDR_W'(idx_s3)
	                                    : SADDR_W'(STATES) + SADDR_W'(idx_s3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sat_q <= 1'b0;
		end else if (req_fire) begin
			sat_q <= 1'b0;
		end else if (y_done) begin
			sat_q <= sat_q | y_clip;
		end else if (x_done) begin
			sat_q <= sat_q | x_clip;
		end
	end

	always_ff @(posedge clk) begin
		if (y_done) begin
			y_q <= y_sat;
		end
	end

	// ---------------------------------------------------------------- output register

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (emit) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_fire) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			rsp_word_q.sample_out <= y_q;
			rsp_word_q.saturated  <= sat_q;
		end
	end

endmodule

// ===== hdl/sfs_check.sv =====
// Port-level assertions for the state-space filter step, bound to the top level.
module sfs_check
	import sfs_pkg::*;
(
	input logic             clk,
	input logic             arst_n,
	input logic             req_valid,
	input logic             req_stall,
	input in_word_t         req_word,
	input logic             rsp_valid,
	input logic             rsp_stall,
	input out_word_t        rsp_word
);

	logic req_fire;

	assign req_fire = req_valid && !req_stall;

	// a stalled result holds its word
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word))
		else $error("stalled result word changed");

	// a sample keeps the block busy while its products run
	a_sample_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_fire && req_word.kind == KIND_SAMPLE |=> req_stall)
		else $error("block took a word while a sample was in flight");

	// a coefficient write or clear leaves the block ready for the next word
	a_single_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		req_fire && (req_word.kind == KIND_COEF || req_word.kind == KIND_CLEAR)
		|=> !req_stall)
		else $error("coefficient write or clear did not finish in one cycle");

	// no result can appear straight after a sample is taken
	a_no_early_result: assert property (@(posedge clk) disable iff (!arst_n)
		req_fire && req_word.kind == KIND_SAMPLE |=> !$rose(rsp_valid))
		else $error("result appeared too early");

	// non-sample words never produce a result in the next cycle
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		req_fire && req_word.kind != KIND_SAMPLE && !rsp_valid |=> !rsp_valid)
		else $error("result produced by a word that gives none");

endmodule

bind state_space_filter_step_top sfs_check u_sfs_check (.*);
